### sv/hlfrd_pkg.sv
// ----------------------------------------------------------------------------
// hlfrd_pkg
// shared types and constants of the header/length frame deframer
// ----------------------------------------------------------------------------
package hlfrd_pkg;

    typedef struct packed {
        logic        mode;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_first;
        logic       frame_last;
    } t_out_word;

    typedef struct packed {
        logic [7:0] topic_command_code;
        logic [7:0] target_command_code;
        logic [7:0] lost_command_code;
        logic [7:0] topic_payload_length;
        logic [7:0] topic_alt_payload_length;
        logic [7:0] target_payload_length;
        logic [7:0] lost_payload_length;
        logic [7:0] frame_overhead_length;
    } t_cfg;

    localparam logic [7:0] REG_TOPIC_CMD     = 8'd0;
    localparam logic [7:0] REG_TARGET_CMD    = 8'd1;
    localparam logic [7:0] REG_LOST_CMD      = 8'd2;
    localparam logic [7:0] REG_TOPIC_LEN     = 8'd3;
    localparam logic [7:0] REG_TOPIC_ALT_LEN = 8'd4;
    localparam logic [7:0] REG_TARGET_LEN    = 8'd5;
    localparam logic [7:0] REG_LOST_LEN      = 8'd6;
    localparam logic [7:0] REG_OVERHEAD      = 8'd7;

    localparam t_cfg CFG_RESET = '{
        topic_command_code:       8'd1,
        target_command_code:      8'd2,
        lost_command_code:        8'd3,
        topic_payload_length:     8'd4,
        topic_alt_payload_length: 8'd2,
        target_payload_length:    8'd8,
        lost_payload_length:      8'd0,
        frame_overhead_length:    8'd5
    };

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [7:0] MIN_FRAME   = 8'd4;
    localparam logic [5:0] RESULT_CAP  = 6'd32;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CHK  = 5'b00100,
        S_ERD  = 5'b01000,
        S_EOUT = 5'b10000
    } t_state;

endpackage

### sv/hlfrd_cfg.sv
// ----------------------------------------------------------------------------
// hlfrd_cfg
// configuration register file, written through a valid/ready channel
// ----------------------------------------------------------------------------
module hlfrd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output hlfrd_pkg::t_cfg   o_cfg
);

    hlfrd_pkg::t_cfg r_cfg;
    hlfrd_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hlfrd_pkg::REG_TOPIC_CMD:     n_cfg.topic_command_code       = i_cfg_data;
                hlfrd_pkg::REG_TARGET_CMD:    n_cfg.target_command_code      = i_cfg_data;
                hlfrd_pkg::REG_LOST_CMD:      n_cfg.lost_command_code        = i_cfg_data;
                hlfrd_pkg::REG_TOPIC_LEN:     n_cfg.topic_payload_length     = i_cfg_data;
                hlfrd_pkg::REG_TOPIC_ALT_LEN: n_cfg.topic_alt_payload_length = i_cfg_data;
                hlfrd_pkg::REG_TARGET_LEN:    n_cfg.target_payload_length    = i_cfg_data;
                hlfrd_pkg::REG_LOST_LEN:      n_cfg.lost_payload_length      = i_cfg_data;
                hlfrd_pkg::REG_OVERHEAD:      n_cfg.frame_overhead_length    = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= hlfrd_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### sv/hlfrd_mem.sv
// ----------------------------------------------------------------------------
// hlfrd_mem
// byte window store, one write and one registered read port
// ----------------------------------------------------------------------------
module hlfrd_mem #(
    parameter int BUFFER_BYTES = 32,
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### sv/hlfrd_seq.sv
// ----------------------------------------------------------------------------
// hlfrd_seq
// window pointers, header scan sequencer and frame emission with output word
// ----------------------------------------------------------------------------
module hlfrd_seq #(
    parameter int BUFFER_BYTES = 32,
    parameter int TIMEOUT_MS   = 20,
    parameter int AW           = $clog2(BUFFER_BYTES),
    parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  hlfrd_pkg::t_in_word   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output hlfrd_pkg::t_out_word  o_out,
    input  hlfrd_pkg::t_cfg       i_cfg,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output logic [7:0]            o_mem_wdata,
    output logic                  o_mem_re,
    output logic [AW-1:0]         o_mem_raddr,
    input  logic [7:0]            i_mem_rdata
);

    localparam logic [8:0]  DEPTH_S = 9'(BUFFER_BYTES);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_BYTES);
    localparam logic [31:0] TIMEOUT_C = 32'(TIMEOUT_MS);

    hlfrd_pkg::t_state    r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [31:0]          r_last_time, n_last_time;
    logic [1:0]           r_k, n_k;
    logic [7:0]           r_i, n_i;
    logic [7:0]           r_flen, n_flen;
    logic [7:0]           r_cmd, n_cmd;
    logic [5:0]           r_prod, n_prod;
    logic                 r_out_valid, n_out_valid;
    hlfrd_pkg::t_out_word r_out, n_out;

    logic       w_accept;
    logic       w_drop;
    logic       w_load;
    logic       w_last;
    logic [7:0] w_flen;
    logic [31:0] w_age;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base, input logic [7:0] off);
        logic [8:0] s;
        s = 9'(base) + 9'(off);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic f_known(input hlfrd_pkg::t_cfg cfg, input logic [7:0] c);
        return (c == cfg.topic_command_code) || (c == cfg.target_command_code) ||
               (c == cfg.lost_command_code);
    endfunction

    function automatic logic f_allowed(input hlfrd_pkg::t_cfg cfg, input logic [7:0] c,
                                       input logic [7:0] len);
        logic ok;
        if (c == cfg.topic_command_code) begin
            ok = (len == cfg.topic_payload_length) || (len == cfg.topic_alt_payload_length);
        end else if (c == cfg.target_command_code) begin
            ok = (len == cfg.target_payload_length);
        end else if (c == cfg.lost_command_code) begin
            ok = (len == cfg.lost_payload_length);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    assign o_in_stall  = (r_state != hlfrd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_accept    = i_in_valid && (r_state == hlfrd_pkg::S_IDLE);
    assign w_age       = i_in.now_ms - r_last_time;
    assign w_last      = (9'(r_i) + 9'd1) == 9'(r_flen);

    always_comb begin
        w_flen = i_cfg.frame_overhead_length + i_mem_rdata;
        if (w_flen < hlfrd_pkg::MIN_FRAME) begin
            w_flen = hlfrd_pkg::MIN_FRAME;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_last_time = r_last_time;
        n_k         = r_k;
        n_i         = r_i;
        n_flen      = r_flen;
        n_cmd       = r_cmd;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = i_in.rx_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = f_wrap(r_head, 8'(r_k));
        w_drop      = 1'b0;
        w_load      = 1'b0;

        unique case (r_state)
            hlfrd_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_prod = '0;
                    if (i_in.mode) begin
                        if ((r_count != '0) && (w_age >= TIMEOUT_C)) begin
                            n_count = '0;
                        end
                    end else begin
                        o_mem_we    = 1'b1;
                        n_last_time = i_in.now_ms;
                        n_k         = '0;
                        n_state     = hlfrd_pkg::S_RD;
                        if (r_count == DEPTH_C) begin
                            o_mem_waddr = r_head;
                            n_head      = f_wrap(r_head, 8'd1);
                        end else begin
                            o_mem_waddr = f_wrap(r_head, 8'(r_count));
                            n_count     = r_count + 1'b1;
                        end
                    end
                end
            end
            hlfrd_pkg::S_RD: begin
                if (9'(r_count) <= 9'(r_k)) begin
                    n_state = hlfrd_pkg::S_IDLE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = f_wrap(r_head, 8'(r_k));
                    n_state     = hlfrd_pkg::S_CHK;
                end
            end
            hlfrd_pkg::S_CHK: begin
                n_state = hlfrd_pkg::S_RD;
                case (r_k)
                    2'd0: w_drop = (i_mem_rdata != hlfrd_pkg::SYNC_FIRST);
                    2'd1: w_drop = (i_mem_rdata != hlfrd_pkg::SYNC_SECOND);
                    2'd2: w_drop = !f_known(i_cfg, i_mem_rdata);
                    default: w_drop = !f_allowed(i_cfg, r_cmd, i_mem_rdata);
                endcase
                if (w_drop) begin
                    n_head  = f_wrap(r_head, 8'd1);
                    n_count = r_count - 1'b1;
                    n_k     = '0;
                end else if (r_k == 2'd3) begin
                    n_flen = w_flen;
                    n_i    = '0;
                    if (9'(r_count) < 9'(w_flen)) begin
                        n_state = hlfrd_pkg::S_IDLE;
                    end else begin
                        n_state = hlfrd_pkg::S_ERD;
                    end
                end else begin
                    if (r_k == 2'd2) begin
                        n_cmd = i_mem_rdata;
                    end
                    n_k = r_k + 1'b1;
                end
            end
            hlfrd_pkg::S_ERD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = f_wrap(r_head, r_i);
                n_state     = hlfrd_pkg::S_EOUT;
            end
            hlfrd_pkg::S_EOUT: begin
                if ((r_prod >= hlfrd_pkg::RESULT_CAP) || !r_out_valid || !i_out_stall) begin
                    if (r_prod < hlfrd_pkg::RESULT_CAP) begin
                        w_load            = 1'b1;
                        n_out_valid       = 1'b1;
                        n_out.frame_byte  = i_mem_rdata;
                        n_out.frame_first = (r_i == '0);
                        n_out.frame_last  = w_last;
                        n_prod            = r_prod + 1'b1;
                    end
                    if (w_last) begin
                        n_head  = f_wrap(r_head, r_flen);
                        n_count = r_count - CW'(r_flen);
                        n_k     = '0;
                        n_state = hlfrd_pkg::S_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = hlfrd_pkg::S_ERD;
                    end
                end
            end
            default: n_state = hlfrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hlfrd_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_last_time <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_prod      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_last_time <= n_last_time;
            r_k         <= n_k;
            r_i         <= n_i;
            r_prod      <= n_prod;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flen <= n_flen;
        r_cmd  <= n_cmd;
        r_out  <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_C) && (9'(r_head) < DEPTH_S))
        else $error("window count or head out of range");

    a_prod_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod <= hlfrd_pkg::RESULT_CAP)
        else $error("result count beyond cap");

    a_first_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_i == '0)) |-> (i_mem_rdata == hlfrd_pkg::SYNC_FIRST))
        else $error("frame start word is not the first sync byte");

    a_drop_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hlfrd_pkg::S_CHK && w_drop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("resync drop did not remove exactly one byte");

endmodule

### sv/header_length_frame_resync_deframer_top.sv
// ----------------------------------------------------------------------------
// header_length_frame_resync_deframer_top
// resynchronizing deframer for 0x55 0xaa / command / length framed byte streams
//
//   channel | direction | handshake            | word
//   in      | input     | i_in_valid/o_in_stall | mode, rx_byte, now_ms
//   out     | output    | o_out_valid/i_out_stall | frame_byte, first, last
//   cfg     | input     | i_cfg_valid/o_cfg_ready | register index, data
//
// a stale check is handled in idle; a received byte is written, then each scanned
// header position is read and checked, each emitted frame byte read and sent,
// until the scan stops at the end of the window, paced by the single read port
// output stalls lengthen emission; one finished word waits in the output register
// reset is synchronous; the window store needs no clearing pass
// ----------------------------------------------------------------------------
module header_length_frame_resync_deframer_top #(
    parameter int BUFFER_BYTES = 32,
    parameter int TIMEOUT_MS   = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  hlfrd_pkg::t_in_word   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output hlfrd_pkg::t_out_word  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);

    hlfrd_pkg::t_cfg w_cfg;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [7:0]      w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    logic [7:0]      w_rdata;

    hlfrd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    hlfrd_mem #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hlfrd_seq #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .TIMEOUT_MS   (TIMEOUT_MS),
        .AW           (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg       (w_cfg),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_re    (w_re),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata)
    );

endmodule
